// ===== rtl/vscfe_pkg.sv =====
// ----------------------------------------------------------------------------
// vscfe_pkg
// Shared types, constants and helpers for the voxel sign-change face emitter.
// ----------------------------------------------------------------------------
package vscfe_pkg;

	// Default grid limit per axis
	localparam int MAX_DIM_DEFAULT = 64;

	// Field widths fixed by the interface
	localparam int SAMPLE_W = 32;
	localparam int SIZE_W   = 7;
	localparam int COORD_W  = 7;
	localparam int CFG_IW   = 2;
	// Compare width for index plus one against an effective size
	localparam int CMP_W    = 9;

	// Face job queue depth between front and back
	localparam int QUEUE_DEPTH = 4;

	// Reset value of every size register
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	// Configuration register indexes
	localparam logic [CFG_IW-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IW-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IW-1:0] REG_SIZE_Z = 2'd2;

	// Face normal axis codes
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// Last vertex number within a quad
	localparam logic [2:0] LAST_VTX = 3'd5;

	// One sample's worth of faces: one bit per axis, lower-neighbour signs,
	// and the base corner (2c-1 on every axis) in half steps
	typedef struct packed {
		logic [2:0]         face_mask;
		logic [2:0]         neg;
		logic [COORD_W-1:0] base_x;
		logic [COORD_W-1:0] base_y;
		logic [COORD_W-1:0] base_z;
	} face_job_t;

	// Base half-step coordinate 2*idx-1, wrapped to the output width
	function automatic logic [COORD_W-1:0] base_coord(input logic [CMP_W-1:0] idx);
		logic [CMP_W:0] t;
		t = {idx, 1'b0} - {{CMP_W{1'b0}}, 1'b1};
		return t[COORD_W-1:0];
	endfunction

	// Quad vertex order v0,v1,v2,v1,v2,v3 mapped to corner number
	function automatic logic [1:0] vertex_corner(input logic [2:0] vtx);
		logic [1:0] c;
		case (vtx)
			3'd0:    c = 2'd0;
			3'd1:    c = 2'd1;
			3'd2:    c = 2'd2;
			3'd3:    c = 2'd1;
			3'd4:    c = 2'd2;
			3'd5:    c = 2'd3;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/voxel_sign_change_face_emitter_unit.sv =====
// ----------------------------------------------------------------------------
// voxel_sign_change_face_emitter_unit
// Cuberille surface extraction over a raster stream of grid samples: one quad
// (six vertices) per sign change against the lower x, y and z neighbour.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    sample
//   out      output     out_valid / out_stall  vert_x/y/z, normal_axis,
//                                              normal_negative, last_vertex
//   cfg      input      cfg_we (no wait)       cfg_index, cfg_data
//
// A sample with no face is taken every cycle; a sample with n faces occupies
// the vertex sequencer for 6*n vertices, one vertex per cycle while out is not stalled.
// Samples keep entering while the four-entry face queue has room, so input
// stalls appear only when the queue fills behind a burst of faces.
// A sample's first vertex passes the classifier stage, a queue slot and the output register.
// Reset clears the grid position, queue and output; sign RAMs need no clear.
// Out stall holds the output register and then backs up through the queue.
// ----------------------------------------------------------------------------
module voxel_sign_change_face_emitter_unit #(
	parameter int MAX_DIM = vscfe_pkg::MAX_DIM_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [vscfe_pkg::CFG_IW-1:0]          cfg_index,
	input  logic [vscfe_pkg::SIZE_W-1:0]          cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [vscfe_pkg::SAMPLE_W-1:0] sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [vscfe_pkg::COORD_W-1:0]         vert_x,
	output logic [vscfe_pkg::COORD_W-1:0]         vert_y,
	output logic [vscfe_pkg::COORD_W-1:0]         vert_z,
	output logic [1:0]                            normal_axis,
	output logic                                  normal_negative,
	output logic                                  last_vertex
);

	logic [vscfe_pkg::SIZE_W-1:0] size_x_q, size_y_q, size_z_q;

	logic                 job_push;
	logic                 job_pop;
	logic                 queue_full;
	logic                 queue_not_empty;
	vscfe_pkg::face_job_t push_job;
	vscfe_pkg::face_job_t head_job;

	// Size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= vscfe_pkg::SIZE_RESET;
			size_y_q <= vscfe_pkg::SIZE_RESET;
			size_z_q <= vscfe_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vscfe_pkg::REG_SIZE_X: size_x_q <= cfg_data;
				vscfe_pkg::REG_SIZE_Y: size_y_q <= cfg_data;
				vscfe_pkg::REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	vscfe_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.size_x     (size_x_q),
		.size_y     (size_y_q),
		.size_z     (size_z_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.queue_full (queue_full),
		.job_push   (job_push),
		.job        (push_job)
	);

	vscfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (job_pop),
		.not_empty (queue_not_empty),
		.head      (head_job)
	);

	vscfe_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (queue_not_empty),
		.job             (head_job),
		.job_pop         (job_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.vert_x          (vert_x),
		.vert_y          (vert_y),
		.vert_z          (vert_z),
		.normal_axis     (normal_axis),
		.normal_negative (normal_negative),
		.last_vertex     (last_vertex)
	);

endmodule

// ===== rtl/vscfe_ram.sv =====
// ----------------------------------------------------------------------------
// vscfe_ram
// Generic single-write, single-read RAM with registered read data.
// A read and write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module vscfe_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read old contents, then write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/vscfe_front.sv =====
// ----------------------------------------------------------------------------
// vscfe_front
// Accepts samples, tracks the grid position, keeps row and plane signs in
// RAM and classifies each sample into a face job for the back end.
// ----------------------------------------------------------------------------
module vscfe_front #(
	parameter int MAX_DIM = vscfe_pkg::MAX_DIM_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [vscfe_pkg::SIZE_W-1:0]         size_x,
	input  logic [vscfe_pkg::SIZE_W-1:0]         size_y,
	input  logic [vscfe_pkg::SIZE_W-1:0]         size_z,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [vscfe_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 queue_full,
	output logic                                 job_push,
	output vscfe_pkg::face_job_t                 job
);

	localparam int IW    = $clog2(MAX_DIM);
	localparam int PDEPTH = MAX_DIM * MAX_DIM;
	localparam int PW    = $clog2(PDEPTH);
	localparam int CW    = vscfe_pkg::CMP_W;

	logic [IW-1:0] index_x_q, index_y_q, index_z_q;
	logic          prev_sign_q;

	logic                               valid_s1;
	logic                               cur_s1;
	logic                               lx_s1;
	logic                               interior_s1;
	logic [vscfe_pkg::COORD_W-1:0]      bx_s1, by_s1, bz_s1;

	logic          accept;
	logic          cur;
	logic          ly, lz;
	logic [PW-1:0] plane_addr;
	logic [2:0]    face_mask;
	logic          s1_free;
	logic [CW-1:0] eff_x, eff_y, eff_z;
	logic          wrap_x, wrap_y, wrap_z;

	// Inside means strictly above zero
	assign cur = !sample[vscfe_pkg::SAMPLE_W-1] && (sample != '0);

	// Clamp sizes to the legal range
	function automatic logic [CW-1:0] eff_size(input logic [vscfe_pkg::SIZE_W-1:0] s);
		logic [CW-1:0] v;
		v = CW'(s);
		if (v < CW'(2)) begin
			v = CW'(2);
		end else if (v > CW'(MAX_DIM)) begin
			v = CW'(MAX_DIM);
		end
		return v;
	endfunction

	assign eff_x  = eff_size(size_x);
	assign eff_y  = eff_size(size_y);
	assign eff_z  = eff_size(size_z);
	assign wrap_x = (CW'(index_x_q) + CW'(1)) >= eff_x;
	assign wrap_y = (CW'(index_y_q) + CW'(1)) >= eff_y;
	assign wrap_z = (CW'(index_z_q) + CW'(1)) >= eff_z;

	// Classify the held sample; empty jobs are dropped without a queue slot
	assign face_mask = {lz != cur_s1, ly != cur_s1, lx_s1 != cur_s1} & {3{interior_s1}};
	assign job_push  = valid_s1 && (face_mask != 3'b000) && !queue_full;
	assign s1_free   = !valid_s1 || (face_mask == 3'b000) || !queue_full;
	assign in_stall  = !s1_free;
	assign accept    = in_valid && s1_free;

	assign job.face_mask = face_mask;
	assign job.neg       = {lz, ly, lx_s1};
	assign job.base_x    = bx_s1;
	assign job.base_y    = by_s1;
	assign job.base_z    = bz_s1;

	assign plane_addr = PW'(index_y_q) * PW'(MAX_DIM) + PW'(index_x_q);

	// Sign of the sample at the same x in the previous row
	vscfe_ram #(
		.WIDTH (1),
		.DEPTH (MAX_DIM)
	) u_row_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (index_x_q),
		.wdata (cur),
		.re    (accept),
		.raddr (index_x_q),
		.rdata (ly)
	);

	// Sign of the sample at the same x,y in the previous plane
	vscfe_ram #(
		.WIDTH (1),
		.DEPTH (PDEPTH)
	) u_plane_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (plane_addr),
		.wdata (cur),
		.re    (accept),
		.raddr (plane_addr),
		.rdata (lz)
	);

	// Advance the raster position, x fastest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_x_q <= '0;
			index_y_q <= '0;
			index_z_q <= '0;
		end else if (accept) begin
			if (wrap_x) begin
				index_x_q <= '0;
				if (wrap_y) begin
					index_y_q <= '0;
					index_z_q <= wrap_z ? '0 : index_z_q + IW'(1);
				end else begin
					index_y_q <= index_y_q + IW'(1);
				end
			end else begin
				index_x_q <= index_x_q + IW'(1);
			end
		end
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the sample and its position
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1      <= cur;
			lx_s1       <= prev_sign_q;
			prev_sign_q <= cur;
			interior_s1 <= (index_x_q != '0) && (index_y_q != '0) && (index_z_q != '0);
			bx_s1       <= vscfe_pkg::base_coord(CW'(index_x_q));
			by_s1       <= vscfe_pkg::base_coord(CW'(index_y_q));
			bz_s1       <= vscfe_pkg::base_coord(CW'(index_z_q));
		end
	end

endmodule

// ===== rtl/vscfe_queue.sv =====
// ----------------------------------------------------------------------------
// vscfe_queue
// Short FIFO of face jobs between the classifier and the vertex sequencer.
// ----------------------------------------------------------------------------
module vscfe_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  vscfe_pkg::face_job_t push_job,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output vscfe_pkg::face_job_t head
);

	localparam int QD  = vscfe_pkg::QUEUE_DEPTH;
	localparam int QAW = $clog2(QD);

	vscfe_pkg::face_job_t store_q [QD];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full      = (count_q == (QAW+1)'(QD));
	assign not_empty = (count_q != '0);
	assign head      = store_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QD-1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QD-1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QAW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QAW+1)'(1);
			end
		end
	end

endmodule

// ===== rtl/vscfe_back.sv =====
// ----------------------------------------------------------------------------
// vscfe_back
// Walks the faces of the head job, six vertices per face, x then y then z,
// into an output register.
// ----------------------------------------------------------------------------
module vscfe_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                job_valid,
	input  vscfe_pkg::face_job_t                job,
	output logic                                job_pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [vscfe_pkg::COORD_W-1:0]       vert_x,
	output logic [vscfe_pkg::COORD_W-1:0]       vert_y,
	output logic [vscfe_pkg::COORD_W-1:0]       vert_z,
	output logic [1:0]                          normal_axis,
	output logic                                normal_negative,
	output logic                                last_vertex
);

	localparam int CW = vscfe_pkg::COORD_W;

	logic [2:0] vtx_q;
	logic [2:0] done_q;
	logic       out_valid_q;
	logic [CW-1:0] vert_x_q, vert_y_q, vert_z_q;
	logic [1:0] axis_q;
	logic       neg_q;
	logic       last_q;

	logic [2:0]       remain;
	logic [2:0]       axis_bit;
	vscfe_pkg::axis_t axis;
	logic [1:0]       corner;
	logic             dx, dy, dz;
	logic             neg;
	logic             last_face;
	logic             quad_end;
	logic             fire;

	// Pick the lowest face not yet walked
	assign remain = job.face_mask & ~done_q;
	always_comb begin
		if (remain[0]) begin
			axis     = vscfe_pkg::AXIS_X;
			axis_bit = 3'b001;
		end else if (remain[1]) begin
			axis     = vscfe_pkg::AXIS_Y;
			axis_bit = 3'b010;
		end else begin
			axis     = vscfe_pkg::AXIS_Z;
			axis_bit = 3'b100;
		end
	end

	assign last_face = (remain & ~axis_bit) == 3'b000;
	assign quad_end  = (vtx_q == vscfe_pkg::LAST_VTX);
	assign neg       = |(job.neg & axis_bit);
	assign corner    = vscfe_pkg::vertex_corner(vtx_q);

	// Map the corner onto the two in-plane axes
	always_comb begin
		unique case (axis)
			vscfe_pkg::AXIS_X: begin
				dx = 1'b0;
				dy = corner[0];
				dz = corner[1];
			end
			vscfe_pkg::AXIS_Y: begin
				dx = corner[0];
				dy = 1'b0;
				dz = corner[1];
			end
			vscfe_pkg::AXIS_Z: begin
				dx = corner[0];
				dy = corner[1];
				dz = 1'b0;
			end
			default: begin
				dx = 1'b0;
				dy = 1'b0;
				dz = 1'b0;
			end
		endcase
	end

	assign fire    = job_valid && (!out_valid_q || !out_stall);
	assign job_pop = fire && quad_end && last_face;

	// Step through vertices and faces
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_q       <= '0;
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				if (quad_end) begin
					vtx_q  <= '0;
					done_q <= last_face ? 3'b000 : (done_q | axis_bit);
				end else begin
					vtx_q <= vtx_q + 3'd1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the vertex into the output register
	always_ff @(posedge clk) begin
		if (fire) begin
			vert_x_q <= job.base_x + {{(CW-2){1'b0}}, dx, 1'b0};
			vert_y_q <= job.base_y + {{(CW-2){1'b0}}, dy, 1'b0};
			vert_z_q <= job.base_z + {{(CW-2){1'b0}}, dz, 1'b0};
			axis_q   <= axis;
			neg_q    <= neg;
			last_q   <= quad_end && last_face;
		end
	end

	assign out_valid       = out_valid_q;
	assign vert_x          = vert_x_q;
	assign vert_y          = vert_y_q;
	assign vert_z          = vert_z_q;
	assign normal_axis     = axis_q;
	assign normal_negative = neg_q;
	assign last_vertex     = last_q;

endmodule

// ===== verif/tb_voxel_sign_change_face_emitter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_voxel_sign_change_face_emitter_unit
// Self-checking bench for the cuberille face emitter. A short directed table
// on a 2x2x2 grid is followed by random grids of assorted sizes. Size
// registers include out-of-range writes and shrinks made part way through
// a grid. A local predictor tracks the grid position and the row and plane
// sign buffers, and expands every sign change into its six quad vertices.
// Each vertex leaving the block is compared field by field with the oldest
// vertex still expected. Both handshakes idle at random, and one long output
// hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_voxel_sign_change_face_emitter_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM        = vscfe_pkg::MAX_DIM_DEFAULT;
	localparam int SAMPLE_W   = vscfe_pkg::SAMPLE_W;
	localparam int SIZE_W     = vscfe_pkg::SIZE_W;
	localparam int COORD_W    = vscfe_pkg::COORD_W;
	localparam int CFG_IW     = vscfe_pkg::CFG_IW;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_LEN   = 200;
	localparam int SETTLE     = 8;
	localparam int RANDOM_N   = 460;
	// Corner numbers of one quad, v0 in the low bits: v0,v1,v2,v1,v2,v3
	localparam logic [11:0] QUAD_CORNERS = {2'd3, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0};

	typedef struct packed {
		logic [COORD_W-1:0] vx;
		logic [COORD_W-1:0] vy;
		logic [COORD_W-1:0] vz;
		vscfe_pkg::axis_t   axis;
		logic               negative;
		logic               last_flag;
	} vertex_t;

	// One directed item; faces and lower_in are {z, y, x}
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       typed;
		logic [2:0]                 faces;
		logic [2:0]                 lower_in;
	} directed_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_IW-1:0]          cfg_index = vscfe_pkg::REG_SIZE_X;
	logic [SIZE_W-1:0]          cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [COORD_W-1:0]         vert_x;
	logic [COORD_W-1:0]         vert_y;
	logic [COORD_W-1:0]         vert_z;
	logic [1:0]                 normal_axis;
	logic                       normal_negative;
	logic                       last_vertex;

	// Predictor state
	logic [SIZE_W-1:0] dim_reg [3];
	int                pos_x = 0;
	int                pos_y = 0;
	int                pos_z = 0;
	logic              row_sign [DIM];
	logic              plane_sign [DIM*DIM];
	vertex_t           pending_vertices [$];

	// Run control and tallies
	bit gaps_on = 1'b1;
	bit stall_on = 1'b1;
	bit hold_pending = 1'b0;
	int mismatches = 0;
	int samples_sent = 0;
	int vertices_checked = 0;
	int settings_used = 0;
	int stall_cycles = 0;
	int quiet_cycles = 0;

	// Three 2x2x2 grids: all outside then max inside, all inside then zero,
	// then a mixed grid with an x and a z change only
	directed_row_t directed_rows [24] = '{
		'{32'sh8000_0000, 1'b1, 3'b000, 3'b000},
		'{-32'sd1,        1'b1, 3'b000, 3'b000},
		'{32'sd0,         1'b1, 3'b000, 3'b000},
		'{32'sh8000_0001, 1'b1, 3'b000, 3'b000},
		'{32'sd0,         1'b1, 3'b000, 3'b000},
		'{-32'sd7,        1'b1, 3'b000, 3'b000},
		'{32'shFFFF_0000, 1'b1, 3'b000, 3'b000},
		'{32'sh7FFF_FFFF, 1'b1, 3'b111, 3'b000},
		'{32'sd1,         1'b1, 3'b000, 3'b000},
		'{32'sh7FFF_FFFF, 1'b1, 3'b000, 3'b000},
		'{32'sd2,         1'b1, 3'b000, 3'b000},
		'{32'sh0000_FFFF, 1'b1, 3'b000, 3'b000},
		'{32'sh5555_5555, 1'b1, 3'b000, 3'b000},
		'{32'sh2AAA_AAAA, 1'b1, 3'b000, 3'b000},
		'{32'sh4000_0000, 1'b1, 3'b000, 3'b000},
		'{32'sd0,         1'b1, 3'b111, 3'b111},
		'{-32'sd1,        1'b0, 3'b000, 3'b000},
		'{-32'sd100,      1'b0, 3'b000, 3'b000},
		'{32'sd0,         1'b0, 3'b000, 3'b000},
		'{32'sd12345,     1'b0, 3'b000, 3'b000},
		'{32'sh8000_0000, 1'b0, 3'b000, 3'b000},
		'{-32'sd3,        1'b0, 3'b000, 3'b000},
		'{32'sd1,         1'b0, 3'b000, 3'b000},
		'{32'sd0,         1'b1, 3'b101, 3'b101}
	};

	voxel_sign_change_face_emitter_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample          (sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.vert_x          (vert_x),
		.vert_y          (vert_y),
		.vert_z          (vert_z),
		.normal_axis     (normal_axis),
		.normal_negative (normal_negative),
		.last_vertex     (last_vertex)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_dim(input logic [SIZE_W-1:0] raw);
		if (raw < 2)
			return 2;
		if (raw > DIM)
			return DIM;
		return int'(raw);
	endfunction

	// Compare one sample with its lower neighbours, store its sign, advance
	function automatic void sign_change_faces(input logic signed [SAMPLE_W-1:0] v,
			output logic [2:0] faces, output logic [2:0] lower_in,
			output logic [COORD_W-1:0] bx, output logic [COORD_W-1:0] by,
			output logic [COORD_W-1:0] bz);
		logic cur;
		cur = (v > 0);
		faces = 3'b000;
		lower_in = 3'b000;
		bx = COORD_W'(2*pos_x - 1);
		by = COORD_W'(2*pos_y - 1);
		bz = COORD_W'(2*pos_z - 1);
		if (pos_x >= 1 && pos_y >= 1 && pos_z >= 1) begin
			lower_in = {plane_sign[pos_x + DIM*pos_y], row_sign[pos_x], row_sign[pos_x-1]};
			faces = lower_in ^ {3{cur}};
		end
		row_sign[pos_x] = cur;
		plane_sign[pos_x + DIM*pos_y] = cur;
		if (pos_x + 1 >= eff_dim(dim_reg[vscfe_pkg::REG_SIZE_X])) begin
			pos_x = 0;
			if (pos_y + 1 >= eff_dim(dim_reg[vscfe_pkg::REG_SIZE_Y])) begin
				pos_y = 0;
				pos_z = (pos_z + 1 >= eff_dim(dim_reg[vscfe_pkg::REG_SIZE_Z])) ? 0 : pos_z + 1;
			end else begin
				pos_y = pos_y + 1;
			end
		end else begin
			pos_x = pos_x + 1;
		end
	endfunction

	// Expand one face into its six vertices
	function automatic void add_quad(input vscfe_pkg::axis_t ax, input logic neg,
			input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by,
			input logic [COORD_W-1:0] bz);
		vertex_t    vtx;
		logic [1:0] corner;
		logic [COORD_W-1:0] du;
		logic [COORD_W-1:0] dv;
		for (int n = 0; n < 6; n++) begin
			corner = QUAD_CORNERS[2*n +: 2];
			du = corner[0] ? COORD_W'(2) : '0;
			dv = corner[1] ? COORD_W'(2) : '0;
			vtx = '{vx: bx, vy: by, vz: bz, axis: ax, negative: neg, last_flag: 1'b0};
			case (ax)
				vscfe_pkg::AXIS_X: begin
					vtx.vy = by + du;
					vtx.vz = bz + dv;
				end
				vscfe_pkg::AXIS_Y: begin
					vtx.vx = bx + du;
					vtx.vz = bz + dv;
				end
				default: begin
					vtx.vx = bx + du;
					vtx.vy = by + dv;
				end
			endcase
			pending_vertices.insert(pending_vertices.size(), vtx);
		end
	endfunction

	function automatic void queue_quads(input logic [2:0] faces, input logic [2:0] lower_in,
			input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by,
			input logic [COORD_W-1:0] bz);
		int before_n;
		before_n = pending_vertices.size();
		if (faces[0])
			add_quad(vscfe_pkg::AXIS_X, lower_in[0], bx, by, bz);
		if (faces[1])
			add_quad(vscfe_pkg::AXIS_Y, lower_in[1], bx, by, bz);
		if (faces[2])
			add_quad(vscfe_pkg::AXIS_Z, lower_in[2], bx, by, bz);
		// Mark the final vertex of this sample
		if (pending_vertices.size() > before_n)
			pending_vertices[pending_vertices.size()-1].last_flag = 1'b1;
	endfunction

	// Random value on the chosen side of zero
	function automatic logic signed [SAMPLE_W-1:0] draw_sample(input bit inside_pt);
		logic signed [SAMPLE_W-1:0] v;
		if (inside_pt) begin
			v = {1'b0, 31'($urandom)};
			if (v == 0)
				v = 32'sd1;
		end else if ($urandom_range(3) == 0) begin
			v = '0;
		end else begin
			v = {1'b1, 31'($urandom)};
		end
		return v;
	endfunction

	// Offer one item, hold it until taken, then predict its vertices
	task automatic offer_sample(input logic signed [SAMPLE_W-1:0] v, input bit typed,
			input logic [2:0] typed_faces, input logic [2:0] typed_lower);
		logic [2:0]         faces;
		logic [2:0]         lower_in;
		logic [COORD_W-1:0] bx;
		logic [COORD_W-1:0] by;
		logic [COORD_W-1:0] bz;
		if (gaps_on && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sign_change_faces(v, faces, lower_in, bx, by, bz);
		if (typed) begin
			faces = typed_faces;
			lower_in = typed_lower;
		end
		queue_quads(faces, lower_in, bx, by, bz);
		samples_sent++;
	endtask

	// Drop valid, wait for every expected vertex, then let the pipe empty
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_vertices.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [SIZE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		dim_reg[idx] = val;
		@(posedge clk);
	endtask

	task automatic configure(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
			input logic [SIZE_W-1:0] sz);
		drain_block();
		write_reg(vscfe_pkg::REG_SIZE_X, sx);
		write_reg(vscfe_pkg::REG_SIZE_Y, sy);
		write_reg(vscfe_pkg::REG_SIZE_Z, sz);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Shrink one axis part way through a grid; only cells already written get read
	task automatic shrink_one_axis();
		logic [CFG_IW-1:0] idx;
		case ($urandom_range(2))
			0:       idx = vscfe_pkg::REG_SIZE_X;
			1:       idx = vscfe_pkg::REG_SIZE_Y;
			default: idx = vscfe_pkg::REG_SIZE_Z;
		endcase
		drain_block();
		write_reg(idx, SIZE_W'($urandom_range(0, eff_dim(dim_reg[idx]))));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Run whole grids; density below zero selects a ball-shaped field.
	// With hold_out set, the receiver holds off once the sizes are in.
	task automatic run_phase(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
			input logic [SIZE_W-1:0] sz, input int grids, input bit shrink_mid,
			input int density, input bit hold_out);
		int ex;
		int ey;
		int ez;
		int cx;
		int cy;
		int cz;
		int r2;
		int d2;
		int n;
		int cut;
		int done;
		bit inside_pt;
		configure(sx, sy, sz);
		if (hold_out)
			hold_pending = 1'b1;
		ex = eff_dim(sx);
		ey = eff_dim(sy);
		ez = eff_dim(sz);
		cx = $urandom_range(0, ex-1);
		cy = $urandom_range(0, ey-1);
		cz = $urandom_range(0, ez-1);
		r2 = $urandom_range(1, (ex*ex + ey*ey + ez*ez)/2 + 1);
		cut = shrink_mid ? $urandom_range(1, ex*ey*ez - 1) : -1;
		n = 0;
		done = 0;
		while (done < grids) begin
			if (n == cut)
				shrink_one_axis();
			d2 = (pos_x-cx)*(pos_x-cx) + (pos_y-cy)*(pos_y-cy) + (pos_z-cz)*(pos_z-cz);
			inside_pt = (density < 0) ? (d2 < r2) : ($urandom_range(99) < density);
			offer_sample(draw_sample(inside_pt), 1'b0, 3'b000, 3'b000);
			n++;
			if (pos_x == 0 && pos_y == 0 && pos_z == 0)
				done++;
		end
	endtask

	// Out-of-range writes only where the axis acts as two
	function automatic logic [SIZE_W-1:0] raw_dim(input int e);
		if (e == 2)
			return SIZE_W'($urandom_range(0, 2));
		return SIZE_W'(e);
	endfunction

	task automatic check_field(input string name, input logic [COORD_W-1:0] want,
			input logic [COORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Check each vertex taken from the block against the oldest expected one
	always @(posedge clk) begin
		vertex_t want;
		if (in_valid && in_stall === 1'b1)
			stall_cycles++;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_vertices.size() == 0) begin
				$error("vertex (%0d,%0d,%0d) arrived with none expected",
					vert_x, vert_y, vert_z);
				mismatches++;
			end else begin
				want = pending_vertices.pop_front();
				check_field("vert_x", want.vx, vert_x);
				check_field("vert_y", want.vy, vert_y);
				check_field("vert_z", want.vz, vert_z);
				check_field("normal_axis", COORD_W'(want.axis), COORD_W'(normal_axis));
				check_field("normal_negative", COORD_W'(want.negative),
					COORD_W'(normal_negative));
				check_field("last_vertex", COORD_W'(want.last_flag), COORD_W'(last_vertex));
				vertices_checked++;
			end
		end
	end

	// End the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == IDLE_LIMIT) begin
			$error("no progress for %0d cycles, %0d vertices outstanding",
				IDLE_LIMIT, pending_vertices.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// Output side: random stalls, plus one long hold-off on request
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
			end else begin
				out_stall <= stall_on && ($urandom_range(99) < 9);
			end
		end
	end

	initial begin : stimulus
		int ex;
		int ey;
		int ez;
		int density;
		for (int r = 0; r < 3; r++)
			dim_reg[r] = vscfe_pkg::SIZE_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table on the smallest grid, written as sizes 0, 1 and 2
		configure(7'd0, 7'd1, 7'd2);
		for (int r = 0; r < $size(directed_rows); r++)
			offer_sample(directed_rows[r].value, directed_rows[r].typed,
				directed_rows[r].faces, directed_rows[r].lower_in);

		// Hold the output long enough for the face queue to fill
		run_phase(7'd5, 7'd5, 7'd4, 1, 1'b0, 50, 1'b1);

		// Largest x extent from an above-range write, no idling on either side
		gaps_on = 1'b0;
		stall_on = 1'b0;
		run_phase(7'd127, 7'd0, 7'd1, 1, 1'b0, 50, 1'b0);
		gaps_on = 1'b1;
		stall_on = 1'b1;

		// Random small grids, some shrunk part way through
		while (samples_sent < RANDOM_N) begin
			ex = $urandom_range(2, 7);
			ey = $urandom_range(2, 7);
			ez = $urandom_range(2, 7);
			case ($urandom_range(3))
				0:       density = 10;
				1:       density = 50;
				2:       density = 90;
				default: density = -1;
			endcase
			run_phase(raw_dim(ex), raw_dim(ey), raw_dim(ez), (ex*ey*ez < 40) ? 3 : 1,
				$urandom_range(2) == 0, density, 1'b0);
		end

		drain_block();
		$display("Covered %0d samples under %0d size settings; %0d vertices compared.",
			samples_sent, settings_used, vertices_checked);
		$display("Input was held back on %0d cycles, including a long output hold-off.",
			stall_cycles);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
